@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the key press rate meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define KPRM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define KPRM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ sv/kprm_pkg.sv @@
// Package for the key press rate meter: constants and transaction types.
`timescale 1ns / 1ps
`default_nettype none
package kprm_pkg;

   localparam int RING_DEPTH = 4;
   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int KEY_W      = 3;
   localparam int COUNT_W    = 8;
   localparam int GREEN_W    = 4;

   localparam logic [COUNT_W-1:0] TICK_LIMIT_RESET = 8'd10;
   localparam logic [COUNT_W-1:0] TICK_COUNT_MAX   = 8'hFF;
   localparam logic [COUNT_W-1:0] BLUE_LEVEL       = 8'd255;
   localparam logic [KEY_W-1:0]   KEYS_RELEASED    = 3'b111;
   localparam logic [POS_W-1:0]   POS_LAST         = POS_W'(RING_DEPTH - 1);

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [KEY_W-1:0] key_pins;
   } kprm_req_type;

   typedef struct packed {
      logic [KEY_W-1:0]   press_mask;
      logic [KEY_W-1:0]   release_mask;
      logic               window_done;
      logic [COUNT_W-1:0] red_duty;
      logic [GREEN_W-1:0] green_duty;
      logic [COUNT_W-1:0] blue_duty;
   } kprm_rsp_type;

endpackage
`default_nettype wire

@@ sv/key_press_rate_meter_unit.sv @@
// Key press rate meter: edge detect, windowed press count and colour output.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted transaction is either a sample of three active-low key pins or a
// timer tick, and yields exactly one result. A new transaction is taken in every
// cycle while req_stall is low: all state (previous keys, press count, tick
// count, window ring and a running ring total) updates in the accept cycle
// through a single short path, and the result goes to an output register backed
// by one skid entry, so req_stall rises only when both are full. Red is the ring
// total minus the entry being overwritten, so it costs one subtract whatever the
// ring depth. Write tick_limit on the csr port only while idle (not enforced).
`include "assert_macros.svh"
module key_press_rate_meter_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire kprm_pkg::kprm_req_type         req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output kprm_pkg::kprm_rsp_type              rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [kprm_pkg::COUNT_W-1:0]         csr_data
);

   // State registers
   logic [kprm_pkg::COUNT_W-1:0] tick_limit_ff;
   logic [kprm_pkg::KEY_W-1:0]   prev_keys_ff, prev_keys_in;
   logic [kprm_pkg::COUNT_W-1:0] presses_ff, presses_in;
   logic [kprm_pkg::COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic [kprm_pkg::COUNT_W-1:0] ring_total_ff, ring_total_in;
   logic [kprm_pkg::POS_W-1:0]   ring_pos_ff, ring_pos_in;
   logic [kprm_pkg::COUNT_W-1:0] ring_ff [kprm_pkg::RING_DEPTH];

   // Output register and skid entry
   logic                   rsp_valid_ff, rsp_valid_in;
   kprm_pkg::kprm_rsp_type rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   kprm_pkg::kprm_rsp_type skid_data_ff, skid_data_in;

   logic                         accept;
   logic                         out_fire;
   logic                         close_window;
   logic [kprm_pkg::COUNT_W-1:0] tick_next;
   logic [kprm_pkg::KEY_W-1:0]   press;
   logic [kprm_pkg::KEY_W-1:0]   release_edges;
   kprm_pkg::kprm_rsp_type       result;
   logic                         rsp_done;
   logic                         rsp_edges;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_fire  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Per-transaction work: edges, press count, tick count and window close
   always_comb begin
      press         = prev_keys_ff & ~req_data.key_pins;
      release_edges = ~prev_keys_ff & req_data.key_pins;
      tick_next     = (tick_count_ff == kprm_pkg::TICK_COUNT_MAX) ? tick_count_ff
                                                                  : tick_count_ff + 8'd1;
      close_window  = (req_data.mode == kprm_pkg::MODE_TICK) && (tick_next > tick_limit_ff);

      prev_keys_in  = prev_keys_ff;
      presses_in    = presses_ff;
      tick_count_in = tick_count_ff;
      ring_total_in = ring_total_ff;
      ring_pos_in   = ring_pos_ff;
      result        = '0;

      if (req_data.mode == kprm_pkg::MODE_SAMPLE) begin
         result.press_mask   = press;
         result.release_mask = release_edges;
         presses_in   = presses_ff + kprm_pkg::COUNT_W'(press[0]) +
                        kprm_pkg::COUNT_W'(press[1]);
         prev_keys_in = req_data.key_pins;
      end else if (close_window) begin
         ring_pos_in   = (ring_pos_ff == kprm_pkg::POS_LAST) ? '0
                                                             : ring_pos_ff + 1'b1;
         // red is the sum of every entry but the new slot
         result.red_duty    = ring_total_ff - ring_ff[ring_pos_in];
         ring_total_in      = result.red_duty + presses_ff;
         result.green_duty  = kprm_pkg::GREEN_W'({ring_pos_in, 2'b00});
         result.blue_duty   = kprm_pkg::BLUE_LEVEL;
         result.window_done = 1'b1;
         tick_count_in      = '0;
         presses_in         = '0;
      end else begin
         tick_count_in = tick_next;
      end
   end

   // Output register with one skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || out_fire) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_limit_ff <= kprm_pkg::TICK_LIMIT_RESET;
         prev_keys_ff  <= kprm_pkg::KEYS_RELEASED;
         presses_ff    <= '0;
         tick_count_ff <= '0;
         ring_total_ff <= '0;
         ring_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tick_limit_ff <= csr_data;
         end
         if (accept) begin
            prev_keys_ff  <= prev_keys_in;
            presses_ff    <= presses_in;
            tick_count_ff <= tick_count_in;
            ring_total_ff <= ring_total_in;
            ring_pos_ff   <= ring_pos_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Window ring; cleared by reset, written on window close
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kprm_pkg::RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (accept && close_window) begin
         ring_ff[ring_pos_in] <= presses_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   assign rsp_done  = rsp_valid_ff && rsp_data_ff.window_done;
   assign rsp_edges = |{rsp_data_ff.press_mask, rsp_data_ff.release_mask};

   `KPRM_ASSERT(a_skid_behind_out, skid_valid_ff |-> rsp_valid_ff, "skid full, output empty")
   `KPRM_ASSERT(a_done_blue, rsp_done |-> (rsp_data_ff.blue_duty == kprm_pkg::BLUE_LEVEL), "blue low")
   `KPRM_ASSERT(a_done_no_edges, rsp_done |-> !rsp_edges, "key edges on a tick")
   `KPRM_ASSERT(a_close_clears, (accept && close_window) |=> !(|{tick_count_ff, presses_ff}), "counts kept")

endmodule
`default_nettype wire
